// ===== rtl/dpl_pkg.sv =====
// Shared types, codes and widths for the descriptor pool unit.
// No dependencies; the top level and the checker refer to it by scoped names.
`timescale 1ns / 1ps

package dpl_pkg;

    // Default sizing, used as the defaults of the top level's parameters
    localparam int POOL_SLOTS_DEF = 64;
    localparam int LOCK_BITS_DEF  = 16;

    // Fixed port widths
    localparam int ACT_W    = 3;
    localparam int REQ_W    = 64;
    localparam int IDX_W    = 6;
    localparam int ID_W     = 64;
    localparam int SIZE_W   = 29;
    localparam int CODE_W   = 2;
    localparam int FCNT_W   = 7;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 29'h1000_0000;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_ALLOC    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FREE     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_LOCK     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_UNLOCK   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_SHUTDOWN = 3'd4;

    // Status codes
    localparam logic [CODE_W-1:0] STAT_OK      = 2'd0;
    localparam logic [CODE_W-1:0] STAT_INVALID = 2'd1;
    localparam logic [CODE_W-1:0] STAT_FULL    = 2'd2;

    // Slot residency codes
    localparam logic [CODE_W-1:0] RES_NONE   = 2'd0;
    localparam logic [CODE_W-1:0] RES_RAM    = 2'd1;
    localparam logic [CODE_W-1:0] RES_LOCKED = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP
    } state_t;

endpackage

// ===== rtl/dpl_slot_ram.sv =====
// Per-slot descriptor memory: allocation id and lock count.
// Single write port, single registered read port. No dependencies.
`timescale 1ns / 1ps

module dpl_slot_ram #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 80
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/dpl_free_find.sv =====
// Lowest-free-slot priority encoder over the busy bit vector.
// No dependencies.
`timescale 1ns / 1ps

module dpl_free_find #(
    parameter int SLOTS  = 64,
    parameter int ADDR_W = 6
) (
    input  logic [SLOTS-1:0]  busy_vec,
    output logic              found,
    output logic [ADDR_W-1:0] slot
);

    always_comb
    begin
        found = 1'b0;
        slot  = '0;
        // scan downward so the lowest free slot wins
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_vec[i])
            begin
                found = 1'b1;
                slot  = ADDR_W'(i);
            end
        end
    end

endmodule

// ===== rtl/descriptor_pool_with_lock_counts_unit.sv =====
// Descriptor pool top level: command FSM, busy bits, id counter, config register.
// Depends on dpl_pkg, dpl_slot_ram and dpl_free_find.
`timescale 1ns / 1ps
//
//  channel   | ports                                              | transaction
//  ----------+----------------------------------------------------+-------------------------
//  command   | start, busy, action, request_size, slot_index,     | start && !busy at clk
//            | slot_present                                       |
//  result    | done, status, granted_slot, granted_id, residency, | done, one cycle wide
//            | freed_while_locked, freed_count                    |
//  config    | cfg_valid, cfg_ready, cfg_data (max_alloc_size)    | cfg_valid && cfg_ready
//
//  Allocate, free, lock, unlock and unknown actions first read the slot RAM, then
//  modify, write back and register the result in the EXEC state. Shutdown passes
//  through EXEC into the sweep, which visits one busy bit a cycle.
//  busy is high from the cycle after a command is taken until its result is
//  registered; done shows in the cycle after, when busy is already low again.
//  Reset clears all busy bits at once, sets the next id to 1 and restores
//  max_alloc_size; no clearing pass is needed. The receiver has no back-pressure.
//
module descriptor_pool_with_lock_counts_unit #(
    parameter int POOL_SLOTS = dpl_pkg::POOL_SLOTS_DEF,
    parameter int LOCK_BITS  = dpl_pkg::LOCK_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // command
    input  logic                          start,
    output logic                          busy,
    input  logic [dpl_pkg::ACT_W-1:0]     action,
    input  logic [dpl_pkg::REQ_W-1:0]     request_size,
    input  logic [dpl_pkg::IDX_W-1:0]     slot_index,
    input  logic                          slot_present,
    // config
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dpl_pkg::SIZE_W-1:0]    cfg_data,
    // result
    output logic                          done,
    output logic [dpl_pkg::CODE_W-1:0]    status,
    output logic [dpl_pkg::IDX_W-1:0]     granted_slot,
    output logic [dpl_pkg::ID_W-1:0]      granted_id,
    output logic [dpl_pkg::CODE_W-1:0]    residency,
    output logic                          freed_while_locked,
    output logic [dpl_pkg::FCNT_W-1:0]    freed_count
);

    localparam int SLOT_W = $clog2(POOL_SLOTS);
    localparam int CNT_W  = $clog2(POOL_SLOTS + 1);
    localparam int RAM_W  = dpl_pkg::ID_W + LOCK_BITS;
    localparam logic [LOCK_BITS-1:0] LOCK_MAX  = '1;
    localparam logic [LOCK_BITS-1:0] LOCK_ONE  = LOCK_BITS'(1);
    localparam logic [SLOT_W-1:0]    LAST_SLOT = SLOT_W'(POOL_SLOTS - 1);

    // Control state
    dpl_pkg::state_t                state_reg, state_next;
    logic [POOL_SLOTS-1:0]          busy_vec_reg, busy_vec_next;
    logic [dpl_pkg::ID_W-1:0]       next_id_reg, next_id_next;
    logic [SLOT_W-1:0]              sweep_reg, sweep_next;
    logic [CNT_W-1:0]               fcount_reg, fcount_next;
    logic [dpl_pkg::SIZE_W-1:0]     max_size_reg;
    logic                           done_reg, done_next;

    // Captured command (payload, no reset)
    logic [dpl_pkg::ACT_W-1:0]      action_reg;
    logic [dpl_pkg::REQ_W-1:0]      size_reg;
    logic [dpl_pkg::IDX_W-1:0]      idx_reg;
    logic                           present_reg;

    // Result payload
    logic [dpl_pkg::CODE_W-1:0]     status_reg, status_next;
    logic [dpl_pkg::IDX_W-1:0]      gslot_reg, gslot_next;
    logic [dpl_pkg::ID_W-1:0]       gid_reg, gid_next;
    logic [dpl_pkg::CODE_W-1:0]     res_reg, res_next;
    logic                           fwl_reg, fwl_next;
    logic [dpl_pkg::FCNT_W-1:0]     fcnt_out_reg, fcnt_out_next;

    // RAM and search
    logic                           accept;
    logic [RAM_W-1:0]               rd_data;
    logic                           wr_en;
    logic [SLOT_W-1:0]              wr_addr;
    logic [RAM_W-1:0]               wr_data;
    logic [dpl_pkg::ID_W-1:0]       rd_id;
    logic [LOCK_BITS-1:0]           rd_locks;
    logic                           free_found;
    logic [SLOT_W-1:0]              free_slot;
    logic [SLOT_W-1:0]              idx_addr;
    logic                           idx_in_range;
    logic                           slot_ok;
    logic                           size_bad;

    assign accept    = start && (state_reg == dpl_pkg::ST_IDLE);
    assign busy      = (state_reg != dpl_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    assign rd_id    = rd_data[RAM_W-1 -: dpl_pkg::ID_W];
    assign rd_locks = rd_data[LOCK_BITS-1:0];

    // slot_index at or above POOL_SLOTS behaves like a free slot
    assign idx_addr     = SLOT_W'(idx_reg);
    assign idx_in_range = (32'(idx_reg) < 32'(POOL_SLOTS));
    assign slot_ok      = present_reg && idx_in_range && busy_vec_reg[idx_addr];
    assign size_bad     = (size_reg == '0) ||
                          (size_reg > dpl_pkg::REQ_W'(max_size_reg));

    dpl_slot_ram #(
        .DEPTH  (POOL_SLOTS),
        .ADDR_W (SLOT_W),
        .DATA_W (RAM_W)
    ) u_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (SLOT_W'(slot_index)),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    dpl_free_find #(
        .SLOTS  (POOL_SLOTS),
        .ADDR_W (SLOT_W)
    ) u_find (
        .busy_vec (busy_vec_reg),
        .found    (free_found),
        .slot     (free_slot)
    );

    // Config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg <= dpl_pkg::SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_size_reg <= cfg_data;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= dpl_pkg::ST_IDLE;
            busy_vec_reg <= '0;
            next_id_reg  <= dpl_pkg::ID_W'(1);
            sweep_reg    <= '0;
            fcount_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            busy_vec_reg <= busy_vec_next;
            next_id_reg  <= next_id_next;
            sweep_reg    <= sweep_next;
            fcount_reg   <= fcount_next;
            done_reg     <= done_next;
        end
    end

    // Command capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg  <= action;
            size_reg    <= request_size;
            idx_reg     <= slot_index;
            present_reg <= slot_present;
        end
        status_reg   <= status_next;
        gslot_reg    <= gslot_next;
        gid_reg      <= gid_next;
        res_reg      <= res_next;
        fwl_reg      <= fwl_next;
        fcnt_out_reg <= fcnt_out_next;
    end

    // Next state and datapath
    always_comb
    begin
        state_next    = state_reg;
        busy_vec_next = busy_vec_reg;
        next_id_next  = next_id_reg;
        sweep_next    = sweep_reg;
        fcount_next   = fcount_reg;
        done_next     = 1'b0;
        status_next   = dpl_pkg::STAT_OK;
        gslot_next    = '0;
        gid_next      = '0;
        res_next      = dpl_pkg::RES_NONE;
        fwl_next      = 1'b0;
        fcnt_out_next = '0;
        wr_en         = 1'b0;
        wr_addr       = idx_addr;
        wr_data       = rd_data;

        case (state_reg)
            dpl_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = dpl_pkg::ST_EXEC;
                end
            end

            dpl_pkg::ST_EXEC:
            begin
                state_next = dpl_pkg::ST_IDLE;
                done_next  = 1'b1;
                case (action_reg)
                    dpl_pkg::ACT_ALLOC:
                    begin
                        if (size_bad)
                        begin
                            status_next = dpl_pkg::STAT_INVALID;
                        end
                        else if (!free_found)
                        begin
                            status_next = dpl_pkg::STAT_FULL;
                        end
                        else
                        begin
                            busy_vec_next[free_slot] = 1'b1;
                            wr_en        = 1'b1;
                            wr_addr      = free_slot;
                            wr_data      = {next_id_reg, {LOCK_BITS{1'b0}}};
                            next_id_next = next_id_reg + 1'b1;
                            gslot_next   = dpl_pkg::IDX_W'(free_slot);
                            gid_next     = next_id_reg;
                            res_next     = dpl_pkg::RES_RAM;
                        end
                    end

                    dpl_pkg::ACT_FREE:
                    begin
                        // released even while locked; RAM contents go stale
                        if (slot_ok)
                        begin
                            busy_vec_next[idx_addr] = 1'b0;
                            gid_next = rd_id;
                            fwl_next = (rd_locks != '0);
                        end
                    end

                    dpl_pkg::ACT_LOCK:
                    begin
                        if (!slot_ok)
                        begin
                            status_next = dpl_pkg::STAT_INVALID;
                        end
                        else
                        begin
                            gid_next = rd_id;
                            res_next = dpl_pkg::RES_LOCKED;
                            if (rd_locks == LOCK_MAX)
                            begin
                                status_next = dpl_pkg::STAT_INVALID;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_data = {rd_id, rd_locks + LOCK_ONE};
                            end
                        end
                    end

                    dpl_pkg::ACT_UNLOCK:
                    begin
                        if (!slot_ok)
                        begin
                            status_next = dpl_pkg::STAT_INVALID;
                        end
                        else
                        begin
                            gid_next = rd_id;
                            if (rd_locks == '0)
                            begin
                                status_next = dpl_pkg::STAT_INVALID;
                                res_next    = dpl_pkg::RES_RAM;
                            end
                            else
                            begin
                                wr_en    = 1'b1;
                                wr_data  = {rd_id, rd_locks - LOCK_ONE};
                                res_next = (rd_locks == LOCK_ONE) ? dpl_pkg::RES_RAM
                                                                  : dpl_pkg::RES_LOCKED;
                            end
                        end
                    end

                    dpl_pkg::ACT_SHUTDOWN:
                    begin
                        done_next   = 1'b0;
                        state_next  = dpl_pkg::ST_SWEEP;
                        sweep_next  = '0;
                        fcount_next = '0;
                    end

                    default:
                    begin
                        status_next = dpl_pkg::STAT_INVALID;
                    end
                endcase
            end

            dpl_pkg::ST_SWEEP:
            begin
                // one slot per cycle: count and release
                if (busy_vec_reg[sweep_reg])
                begin
                    busy_vec_next[sweep_reg] = 1'b0;
                    fcount_next = fcount_reg + 1'b1;
                end
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == LAST_SLOT)
                begin
                    state_next    = dpl_pkg::ST_IDLE;
                    done_next     = 1'b1;
                    next_id_next  = dpl_pkg::ID_W'(1);
                    fcnt_out_next = dpl_pkg::FCNT_W'(fcount_next);
                end
            end

            default:
            begin
                state_next = dpl_pkg::ST_IDLE;
            end
        endcase
    end

    assign done               = done_reg;
    assign status             = status_reg;
    assign granted_slot       = gslot_reg;
    assign granted_id         = gid_reg;
    assign residency          = res_reg;
    assign freed_while_locked = fwl_reg;
    assign freed_count        = fcnt_out_reg;

endmodule

// ===== rtl/dpl_checker.sv =====
// Port-level checker for the descriptor pool unit, bound to the top level.
// Depends on dpl_pkg and descriptor_pool_with_lock_counts_unit.
`timescale 1ns / 1ps

module dpl_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic [dpl_pkg::CODE_W-1:0]  status,
    input logic [dpl_pkg::IDX_W-1:0]   granted_slot,
    input logic [dpl_pkg::ID_W-1:0]    granted_id,
    input logic [dpl_pkg::CODE_W-1:0]  residency,
    input logic                        freed_while_locked,
    input logic [dpl_pkg::FCNT_W-1:0]  freed_count
);

    // a taken command keeps the unit busy for at least the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("command taken but unit not busy next cycle");

    // results arrive only after the work is done
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobed while still busy");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == dpl_pkg::STAT_OK || status == dpl_pkg::STAT_INVALID ||
                  status == dpl_pkg::STAT_FULL))
        else $error("status code out of range");

    // a failed command never grants a slot or reports a locked release
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != dpl_pkg::STAT_OK |-> granted_slot == '0 && !freed_while_locked)
        else $error("failed command reported a grant or release");

    // a shutdown result that freed slots carries no residency or id and reports OK
    a_shutdown_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && freed_count != '0 |->
            residency == dpl_pkg::RES_NONE && granted_id == '0 && status == dpl_pkg::STAT_OK)
        else $error("shutdown result carries slot fields");

endmodule

bind descriptor_pool_with_lock_counts_unit dpl_checker u_dpl_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .done               (done),
    .status             (status),
    .granted_slot       (granted_slot),
    .granted_id         (granted_id),
    .residency          (residency),
    .freed_while_locked (freed_while_locked),
    .freed_count        (freed_count)
);
